// ----- rtl/ccc_pkg.sv -----
// Shared types and codes for the snooping coherent cache controller.
package ccc_pkg;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] address;
    logic        other_copy;
  } in_word_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] bus_request;
    logic       victim_writeback;
    logic       flush;
    logic       intervention;
    logic       invalidated;
    logic [2:0] new_state;
  } out_word_t;

  // Opcodes of an input word.
  localparam logic [2:0] OP_PRD    = 3'd0;
  localparam logic [2:0] OP_PWR    = 3'd1;
  localparam logic [2:0] OP_BUSRD  = 3'd2;
  localparam logic [2:0] OP_BUSRDX = 3'd3;
  localparam logic [2:0] OP_BUSUPG = 3'd4;
  localparam logic [2:0] OP_BUSUPD = 3'd5;

  // Line states.
  localparam logic [2:0] ST_I  = 3'd0;
  localparam logic [2:0] ST_S  = 3'd1;
  localparam logic [2:0] ST_E  = 3'd2;
  localparam logic [2:0] ST_M  = 3'd3;
  localparam logic [2:0] ST_SM = 3'd4;

  // Bus requests.
  localparam logic [2:0] BUS_NONE   = 3'd0;
  localparam logic [2:0] BUS_RD     = 3'd1;
  localparam logic [2:0] BUS_RDX    = 3'd2;
  localparam logic [2:0] BUS_UPGR   = 3'd3;
  localparam logic [2:0] BUS_UPD    = 3'd4;
  localparam logic [2:0] BUS_RD_UPD = 3'd5;

  // Protocol modes.
  localparam logic [1:0] MODE_MSI    = 2'd0;
  localparam logic [1:0] MODE_MESI   = 2'd1;
  localparam logic [1:0] MODE_DRAGON = 2'd2;

endpackage

// ----- rtl/ccc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ccc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/ccc_front.sv -----
// Front end: accepts words, splits the address into set and tag, and queues them.
module ccc_front #(
  parameter int NUM_SETS    = 64,
  parameter int BLOCK_BYTES = 64,
  parameter int ADDR_BITS   = 32,
  parameter int SET_W       = 6,
  parameter int TAG_W       = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  ccc_pkg::in_word_t in_word,
  input  logic             hold,
  output logic             busy,
  output logic             q_valid,
  input  logic             q_pop,
  output logic [2:0]       q_op,
  output logic             q_other,
  output logic [SET_W-1:0] q_set,
  output logic [TAG_W-1:0] q_tag
);
  import ccc_pkg::*;

  localparam int OFF_W  = $clog2(BLOCK_BYTES);
  localparam int SB     = $clog2(NUM_SETS);
  localparam int EFF_W  = ADDR_BITS < 32 ? ADDR_BITS : 32;
  localparam int ITEM_W = 3 + 1 + SET_W + TAG_W;

  logic [31:0]       addr_eff;
  logic [31:0]       blk;
  logic [ITEM_W-1:0] item;
  logic [ITEM_W-1:0] slot_r [2];
  logic              wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              push;

  assign addr_eff = (EFF_W == 32) ? in_word.address
                  : (in_word.address & ((32'd1 << EFF_W) - 32'd1));
  assign blk  = addr_eff >> OFF_W;
  assign item = {in_word.opcode, in_word.other_copy,
                 SET_W'(blk & 32'(NUM_SETS - 1)), TAG_W'(blk >> SB)};

  assign busy = (cnt_r == 2'd2) || hold;
  assign push = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign {q_op, q_other, q_set, q_tag} = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= item;
    end
  end
endmodule

// ----- rtl/ccc_back.sv -----
// Back end: reads a set, applies the coherence transition, writes the set back.
module ccc_back #(
  parameter int NUM_SETS = 64,
  parameter int NUM_WAYS = 8,
  parameter int SET_W    = 6,
  parameter int TAG_W    = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        mode_cfg,
  input  logic              q_valid,
  output logic              q_pop,
  input  logic [2:0]        q_op,
  input  logic              q_other,
  input  logic [SET_W-1:0]  q_set,
  input  logic [TAG_W-1:0]  q_tag,
  output logic              clearing,
  output logic              out_valid,
  output ccc_pkg::out_word_t out_word
);
  import ccc_pkg::*;

  localparam int WW = NUM_WAYS > 1 ? $clog2(NUM_WAYS) : 1;

  typedef logic [NUM_WAYS-1:0][TAG_W-1:0] tag_row_t;
  typedef logic [NUM_WAYS-1:0][2:0]       st_row_t;
  typedef logic [NUM_WAYS-1:0][31:0]      stamp_row_t;

  logic             ex_r;
  logic [2:0]       ex_op_r;
  logic             ex_oth_r;
  logic [SET_W-1:0] ex_set_r;
  logic [TAG_W-1:0] ex_tag_r;
  logic             fwd_r;
  tag_row_t         fwd_tag_r;
  st_row_t          fwd_st_r;
  stamp_row_t       fwd_stamp_r;
  logic             clr_r;
  logic [SET_W-1:0] clr_cnt_r;
  logic [31:0]      aclk_r;
  logic             out_valid_r;
  out_word_t        out_word_r;

  tag_row_t   tag_rd, tr, tag_n;
  st_row_t    st_rd, sr, st_n;
  stamp_row_t stamp_rd, mr, stamp_n;
  logic [31:0] aclk_nxt;
  logic [1:0]  mode;
  logic        hit, inv_found, is_proc, wr, do_wr;
  logic [WW-1:0] hway, vinv, vlru, way;
  logic [31:0]   best;
  logic [2:0]    st, bus;
  logic          wb, fl, itv, inv;
  out_word_t     res;
  logic          st_we;
  logic [SET_W-1:0] st_waddr;
  st_row_t       st_wdata;
  stamp_row_t    stamp_wdata;

  assign q_pop    = q_valid && !clr_r;
  assign clearing = clr_r;
  assign aclk_nxt = aclk_r + 32'd1;
  assign mode     = (mode_cfg == MODE_MESI || mode_cfg == MODE_DRAGON) ? mode_cfg : MODE_MSI;

  assign tr = fwd_r ? fwd_tag_r : tag_rd;
  assign sr = fwd_r ? fwd_st_r : st_rd;
  assign mr = fwd_r ? fwd_stamp_r : stamp_rd;

  always_comb begin
    hit = 1'b0;
    hway = '0;
    inv_found = 1'b0;
    vinv = '0;
    best = 32'hFFFF_FFFF;
    vlru = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!hit && sr[w] != ST_I && tr[w] == ex_tag_r) begin
        hit = 1'b1;
        hway = WW'(w);
      end
      if (!inv_found && sr[w] == ST_I) begin
        inv_found = 1'b1;
        vinv = WW'(w);
      end
      if (mr[w] <= best) begin
        best = mr[w];
        vlru = WW'(w);
      end
    end
  end

  always_comb begin
    is_proc = (ex_op_r == OP_PRD) || (ex_op_r == OP_PWR);
    wr  = (ex_op_r == OP_PWR);
    way = hit ? hway : (inv_found ? vinv : vlru);
    st  = hit ? sr[hway] : ST_I;
    bus = BUS_NONE;
    wb  = 1'b0;
    fl  = 1'b0;
    itv = 1'b0;
    inv = 1'b0;
    tag_n = tr;
    stamp_n = mr;
    if (is_proc) begin
      if (!hit) begin
        wb = (sr[way] == ST_M) || (sr[way] == ST_SM);
        tag_n[way] = ex_tag_r;
        if (mode == MODE_MSI) begin
          st  = wr ? ST_M : ST_S;
          bus = wr ? BUS_RDX : BUS_RD;
        end else if (mode == MODE_MESI) begin
          st  = wr ? ST_M : (ex_oth_r ? ST_S : ST_E);
          bus = wr ? BUS_RDX : BUS_RD;
        end else if (wr) begin
          st  = ex_oth_r ? ST_SM : ST_M;
          bus = ex_oth_r ? BUS_RD_UPD : BUS_RD;
        end else begin
          st  = ex_oth_r ? ST_S : ST_E;
          bus = BUS_RD;
        end
      end else if (wr) begin
        if (mode == MODE_MSI) begin
          if (st == ST_S) begin
            st = ST_M;
            bus = BUS_RDX;
          end
        end else if (mode == MODE_MESI) begin
          if (st == ST_S) begin
            st = ST_M;
            bus = BUS_UPGR;
          end else if (st == ST_E) begin
            st = ST_M;
          end
        end else begin
          if (st == ST_E) begin
            st = ST_M;
          end else if (st == ST_S || st == ST_SM) begin
            st = ex_oth_r ? ST_SM : ST_M;
            bus = BUS_UPD;
          end
        end
      end
      stamp_n[way] = aclk_nxt;
    end else if (hit) begin
      if (ex_op_r == OP_BUSRD) begin
        if (mode == MODE_DRAGON) begin
          if (st == ST_E) begin
            st = ST_S;
            itv = 1'b1;
          end else if (st == ST_M) begin
            st = ST_SM;
            fl = 1'b1;
            itv = 1'b1;
          end else if (st == ST_SM) begin
            fl = 1'b1;
          end
        end else begin
          if (st == ST_M) begin
            st = ST_S;
            fl = 1'b1;
            itv = 1'b1;
          end else if (st == ST_E && mode == MODE_MESI) begin
            st = ST_S;
            itv = 1'b1;
          end
        end
      end else if (ex_op_r == OP_BUSRDX && mode != MODE_DRAGON) begin
        if (st == ST_M) begin
          st = ST_I;
          fl = 1'b1;
          inv = 1'b1;
        end else if (st == ST_S || (st == ST_E && mode == MODE_MESI)) begin
          st = ST_I;
          inv = 1'b1;
        end
      end else if (ex_op_r == OP_BUSUPG && mode == MODE_MESI) begin
        if (st == ST_S) begin
          st = ST_I;
          inv = 1'b1;
        end
      end else if (ex_op_r == OP_BUSUPD && mode == MODE_DRAGON) begin
        if (st == ST_SM) begin
          st = ST_S;
        end
      end
    end
    do_wr = hit || is_proc;
    st_n = sr;
    if (do_wr) begin
      st_n[way] = st;
    end
    res.hit = hit;
    res.bus_request = bus;
    res.victim_writeback = wb;
    res.flush = fl;
    res.intervention = itv;
    res.invalidated = inv;
    res.new_state = st;
  end

  // The clearing pass shares the write ports of the state and stamp memories.
  assign st_we       = ex_r || clr_r;
  assign st_waddr    = clr_r ? clr_cnt_r : ex_set_r;
  assign st_wdata    = clr_r ? '0 : st_n;
  assign stamp_wdata = clr_r ? '0 : stamp_n;

  ccc_ram #(.WIDTH(NUM_WAYS * TAG_W), .DEPTH(NUM_SETS)) u_tag_ram (
    .clk(clk), .we(ex_r), .waddr(ex_set_r), .wdata(tag_n),
    .raddr(q_set), .rdata(tag_rd)
  );

  ccc_ram #(.WIDTH(NUM_WAYS * 3), .DEPTH(NUM_SETS)) u_st_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(q_set), .rdata(st_rd)
  );

  ccc_ram #(.WIDTH(NUM_WAYS * 32), .DEPTH(NUM_SETS)) u_stamp_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(stamp_wdata),
    .raddr(q_set), .rdata(stamp_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_r        <= 1'b0;
      fwd_r       <= 1'b0;
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      aclk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ex_r        <= q_pop;
      fwd_r       <= ex_r && q_pop && (q_set == ex_set_r);
      out_valid_r <= ex_r;
      if (ex_r) begin
        aclk_r <= aclk_nxt;
      end
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == SET_W'(NUM_SETS - 1)) begin
          clr_r <= 1'b0;
        end
      end
    end
    if (q_pop) begin
      ex_op_r  <= q_op;
      ex_oth_r <= q_other;
      ex_set_r <= q_set;
      ex_tag_r <= q_tag;
    end
    fwd_tag_r   <= tag_n;
    fwd_st_r    <= st_n;
    fwd_stamp_r <= stamp_n;
    out_word_r  <= res;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
endmodule

// ----- rtl/snooping_coherent_cache_controller.sv -----
// Top level of the snooping coherent cache controller (MSI, MESI, Dragon).
//
//   channel  ports                         handshake
//   input    start, busy, in_word          taken when start is high and busy is low
//   result   out_valid, out_word           one-cycle strobe, always taken
//   config   cfg_valid, cfg_ready, cfg_data written when valid and ready are high
//
// A word passes through the queue and the set read, and its result is
// then registered onto the outputs; words follow one per cycle outside the
// clearing pass, because a set just written is forwarded to a following
// word to the same set. After reset the state and stamp memories are
// cleared, one set per cycle, all NUM_SETS of them; busy stays high meanwhile.
// Busy also rises when the two-entry queue is full. The receiver cannot stall.
module snooping_coherent_cache_controller #(
  parameter int NUM_SETS    = 64,
  parameter int NUM_WAYS    = 8,
  parameter int BLOCK_BYTES = 64,
  parameter int ADDR_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ccc_pkg::in_word_t  in_word,
  output logic               out_valid,
  output ccc_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data
);
  import ccc_pkg::*;

  // Set index is at least one bit wide so that a single-set cache still works.
  localparam int SB    = $clog2(NUM_SETS);
  localparam int SET_W = SB > 0 ? SB : 1;
  localparam int EFF_W = ADDR_BITS < 32 ? ADDR_BITS : 32;
  localparam int TAG_W = EFF_W - $clog2(BLOCK_BYTES) - SB;

  logic [1:0]       protocol_mode_r;
  logic             clearing;
  logic             q_valid, q_pop, q_other;
  logic [2:0]       q_op;
  logic [SET_W-1:0] q_set;
  logic [TAG_W-1:0] q_tag;

  // The user must write the mode register only while the controller is idle; the block itself does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      protocol_mode_r <= MODE_MSI;
    end else if (cfg_valid && cfg_ready) begin
      protocol_mode_r <= cfg_data;
    end
  end

  ccc_front #(
    .NUM_SETS(NUM_SETS), .BLOCK_BYTES(BLOCK_BYTES), .ADDR_BITS(ADDR_BITS),
    .SET_W(SET_W), .TAG_W(TAG_W)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_word(in_word),
    .hold(clearing), .busy(busy), .q_valid(q_valid), .q_pop(q_pop),
    .q_op(q_op), .q_other(q_other), .q_set(q_set), .q_tag(q_tag)
  );

  ccc_back #(
    .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .SET_W(SET_W), .TAG_W(TAG_W)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .mode_cfg(protocol_mode_r),
    .q_valid(q_valid), .q_pop(q_pop), .q_op(q_op), .q_other(q_other),
    .q_set(q_set), .q_tag(q_tag), .clearing(clearing),
    .out_valid(out_valid), .out_word(out_word)
  );

  // No result can come out while the memories are still being cleared.
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid) else $error("result during clearing pass");

  // A victim writeback only happens on a miss.
  a_wb_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.victim_writeback |-> !out_word.hit)
    else $error("writeback on a hit");

  // Snoop effects need a hit and never come with a bus request.
  a_snoop_effects: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.flush || out_word.intervention || out_word.invalidated)
    |-> out_word.hit && out_word.bus_request == BUS_NONE)
    else $error("snoop effect without hit or with request");

  // An invalidated line must end in the invalid state.
  a_inv_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.invalidated |-> out_word.new_state == ST_I)
    else $error("invalidated line not invalid");
endmodule
